[rtl/mht_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mht_pkg: shared constants for the multi-turn heading tracker
// Port field widths and default sizing of the internal sample, heading and
// turn-count datapaths.
// ----------------------------------------------------------------------------
package mht_pkg;

    // Fixed widths of the item fields on the ports
    localparam int RAW_HEADING_W = 16;
    localparam int HEADING_W     = 32;
    localparam int TURNS_W       = 16;

    // Default internal sizing
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int HEADING_BITS_DEF = 32;
    localparam int TURN_BITS_DEF    = 16;

endpackage

[rtl/mht_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mht_if: item channels of the multi-turn heading tracker
// Valid/ready channels for the yaw sample input and the heading result.
// ----------------------------------------------------------------------------
interface mht_in_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [mht_pkg::RAW_HEADING_W-1:0]   raw_heading;

    modport source (output valid, output raw_heading, input ready);
    modport sink   (input valid, input raw_heading, output ready);
endinterface

interface mht_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [mht_pkg::HEADING_W-1:0]   heading;
    logic signed [mht_pkg::TURNS_W-1:0]     turns;
    logic                                   wrapped;

    modport source (output valid, output heading, output turns, output wrapped,
                    input ready);
    modport sink   (input valid, input heading, input turns, input wrapped,
                    output ready);
endinterface

[rtl/mht_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mht_update: one-sample heading update
// Detects a wrap between the previous and new sample, moves the turn count
// and produces the next accumulated heading.
// ----------------------------------------------------------------------------
module mht_update #(
    parameter int SAMPLE_BITS  = 16,
    parameter int HEADING_BITS = 32,
    parameter int TURN_BITS    = 16
) (
    input  logic signed [SAMPLE_BITS-1:0]  i_raw,
    input  logic signed [SAMPLE_BITS-1:0]  i_prev,
    input  logic signed [TURN_BITS-1:0]    i_turns,
    input  logic signed [HEADING_BITS-1:0] i_acc,
    output logic signed [TURN_BITS-1:0]    o_turns,
    output logic signed [HEADING_BITS-1:0] o_acc,
    output logic                           o_wrapped
);
    localparam logic [SAMPLE_BITS:0] HALF_TURN = (SAMPLE_BITS+1)'(1) << (SAMPLE_BITS - 2);

    logic signed [SAMPLE_BITS:0]   delta;      // raw - prev, exact
    logic        [SAMPLE_BITS:0]   mag;
    logic                          raw_pos;
    logic signed [TURN_BITS-1:0]   moved_turns;
    logic signed [HEADING_BITS-1:0] wrap_heading;
    logic signed [HEADING_BITS-1:0] step_heading;

    // exact sample difference and its magnitude
    assign delta = (SAMPLE_BITS+1)'(i_raw) - (SAMPLE_BITS+1)'(i_prev);
    assign mag   = delta[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-delta) : delta;

    assign o_wrapped = (mag > HALF_TURN);
    assign raw_pos   = !i_raw[SAMPLE_BITS-1] && (i_raw != '0);

    // on a wrap the count moves down on a positive sample, up otherwise; else hold
    assign moved_turns = raw_pos ? i_turns - TURN_BITS'(1) : i_turns + TURN_BITS'(1);
    assign o_turns     = o_wrapped ? moved_turns : i_turns;

    // after a wrap the heading is full_turn * count + raw (also covers count zero)
    assign wrap_heading = (HEADING_BITS'(moved_turns) << (SAMPLE_BITS - 1))
                        + HEADING_BITS'(i_raw);
    assign step_heading = i_acc + HEADING_BITS'(delta);

    assign o_acc = o_wrapped ? wrap_heading : step_heading;

endmodule

[rtl/multiturn_heading_tracker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiturn_heading_tracker_unit: multi-turn yaw unwrapper
// Path: the sample is held in the input register on accept, then the update
//   result enters the state/result register once that register is free or drains.
// Throughput: one item per cycle while the result is taken; the turn count
//   and heading update is combinational, so consecutive samples chain through the state.
// Reset: synchronous, active low; clears both stage valids, the previous
//   sample, the turn count and the accumulated heading.
// ----------------------------------------------------------------------------
module multiturn_heading_tracker_unit #(
    parameter int SAMPLE_BITS  = mht_pkg::SAMPLE_BITS_DEF,
    parameter int HEADING_BITS = mht_pkg::HEADING_BITS_DEF,
    parameter int TURN_BITS    = mht_pkg::TURN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mht_in_if.sink      i_in,
    mht_out_if.source   o_out
);
    import mht_pkg::*;

    // input stage
    logic                           r_in_valid;
    logic signed [SAMPLE_BITS-1:0]  r_raw;

    // state, which doubles as the result register
    logic                           r_out_valid;
    logic signed [SAMPLE_BITS-1:0]  r_prev;
    logic signed [TURN_BITS-1:0]    r_turns;
    logic signed [HEADING_BITS-1:0] r_acc;
    logic                           r_wrapped;

    logic                           n_out_valid;
    logic signed [TURN_BITS-1:0]    n_turns;
    logic signed [HEADING_BITS-1:0] n_acc;
    logic                           n_wrapped;

    logic                           advance;
    logic                           take_in;

    // move the input stage on when the result register is free or drains
    assign advance  = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign take_in  = i_in.valid && i_in.ready;

    // hold the incoming sample, low SAMPLE_BITS bits of the field
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (take_in) begin
            r_raw <= SAMPLE_BITS'($unsigned(i_in.raw_heading));
        end
    end

    mht_update #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .HEADING_BITS (HEADING_BITS),
        .TURN_BITS    (TURN_BITS)
    ) u_update (
        .i_raw     (r_raw),
        .i_prev    (r_prev),
        .i_turns   (r_turns),
        .i_acc     (r_acc),
        .o_turns   (n_turns),
        .o_acc     (n_acc),
        .o_wrapped (n_wrapped)
    );

    assign n_out_valid = r_in_valid || (r_out_valid && !o_out.ready);

    // advance state and result on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_turns     <= '0;
            r_acc       <= '0;
            r_wrapped   <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= n_out_valid;
            end
            if (advance && r_in_valid) begin
                r_prev    <= r_raw;
                r_turns   <= n_turns;
                r_acc     <= n_acc;
                r_wrapped <= n_wrapped;
            end
        end
    end

    // drive the result item
    assign o_out.valid   = r_out_valid;
    assign o_out.heading = HEADING_W'(r_acc);
    assign o_out.turns   = TURNS_W'(r_turns);
    assign o_out.wrapped = r_wrapped;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the multi-turn heading tracker
// Feeds yaw samples through the valid/ready channels and checks every
// heading, turn count and wrap flag against a bit-true unwrapper kept in a
// scoreboard. Covers the half-turn boundary, zero samples on a wrap, the
// count returning to zero and long runs of wraps in both directions.
// ----------------------------------------------------------------------------
module tb;

    localparam int  SAMPLE_W  = mht_pkg::RAW_HEADING_W;
    localparam int  FULL_TURN = 1 << (mht_pkg::SAMPLE_BITS_DEF - 1);
    localparam int  HALF_TURN = 1 << (mht_pkg::SAMPLE_BITS_DEF - 2);
    localparam int  DRAIN_CYCLES = 8;
    localparam int  DRAIN_LIMIT  = 20000;
    localparam int  ROLL_STEPS   = 40;

    typedef logic signed [SAMPLE_W-1:0]          t_sample;
    typedef logic signed [mht_pkg::HEADING_W-1:0] t_heading;
    typedef logic signed [mht_pkg::TURNS_W-1:0]   t_turns;

    typedef struct packed {
        t_heading heading;
        t_turns   turns;
        logic     wrapped;
    } t_heading_result;

    // Unwrapper prediction and queue of pending headings
    class heading_scoreboard;
        t_sample         last_sample;
        t_turns          turn_cnt;
        t_heading        heading_sum;
        t_heading_result pending_q[$];
        int              errors;

        function new();
            last_sample = '0;
            turn_cnt    = '0;
            heading_sum = '0;
            errors      = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return pending_q.size();
        endfunction

        // Advance the unwrapper by one accepted sample
        function void note_sample(t_sample s);
            int              raw_i;
            int              prev_i;
            int              delta;
            int              mag;
            int              dir;
            int              abs_raw;
            longint          acc;
            logic            wrap;
            t_heading_result r;
            raw_i  = s;
            prev_i = last_sample;
            delta  = prev_i - raw_i;
            mag    = (delta < 0) ? -delta : delta;
            wrap   = (mag > HALF_TURN);
            if (wrap) begin
                dir      = (raw_i > 0) ? -1 : 1;
                turn_cnt = t_turns'(int'(turn_cnt) + dir);
                if (turn_cnt == 0) begin
                    heading_sum = t_heading'(raw_i);
                end else begin
                    abs_raw     = (raw_i < 0) ? -raw_i : raw_i;
                    acc         = longint'(FULL_TURN) * longint'(turn_cnt)
                                  - longint'(dir * HALF_TURN)
                                  + longint'(dir * (HALF_TURN - abs_raw));
                    heading_sum = acc[mht_pkg::HEADING_W-1:0];
                end
            end else begin
                heading_sum = heading_sum + t_heading'(raw_i - prev_i);
            end
            last_sample = s;
            r.heading = heading_sum;
            r.turns   = turn_cnt;
            r.wrapped = wrap;
            pending_q.push_back(r);
        endfunction

        // Compare one accepted result with the oldest expectation
        task check_result(t_heading heading, t_turns turns, logic wrapped);
            t_heading_result want;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result heading=%0d turns=%0d wrapped=%0b",
                                 heading, turns, wrapped));
                return;
            end
            want = pending_q.pop_front();
            if (heading !== want.heading)
                report($sformatf("heading got %0d want %0d", heading, want.heading));
            if (turns !== want.turns)
                report($sformatf("turns got %0d want %0d", turns, want.turns));
            if (wrapped !== want.wrapped)
                report($sformatf("wrapped got %0b want %0b", wrapped, want.wrapped));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mht_in_if  in_if();
    mht_out_if out_if();

    heading_scoreboard sb = new();

    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    int      rx_hold     = 0;
    t_sample walk_pos    = '0;
    t_sample last_sent   = '0;

    multiturn_heading_tracker_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Give up after a generous fixed time
    initial begin
        #10ms;
        $display("tb: errors");
        $finish;
    end

    // Note every accepted sample
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            sb.note_sample(in_if.raw_heading);
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.heading, out_if.turns, out_if.wrapped);
    end

    // Drive result ready: random stalls, or a long hold when requested
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                out_if.ready <= 1'b0;
                rx_hold--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one sample, with random idle cycles ahead of it; return on accept
    task automatic send_sample(input t_sample s);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.raw_heading <= s;
        do @(posedge i_clk); while (!in_if.ready);
        last_sent = s;
    endtask

    // Drop valid and hold until every expected result has come back or DRAIN_LIMIT runs out
    task automatic wait_drained();
        int n;
        n = 0;
        in_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            n++;
        end while (sb.pending() != 0 && n < DRAIN_LIMIT);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
    endtask

    // Mostly a smooth rotation that crosses the sample range, some noise
    task automatic send_random(input int count);
        int      k;
        int      sel;
        int      step;
        t_sample s;
        for (k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            if (sel < 25) begin
                s = t_sample'($urandom);
            end else begin
                if (sel < 35)
                    step = $urandom_range(HALF_TURN + 8, HALF_TURN - 8);
                else if (sel < 40)
                    step = $urandom_range(FULL_TURN - 1, HALF_TURN);
                else
                    step = $urandom_range(2000);
                if ($urandom_range(1))
                    step = -step;
                walk_pos = walk_pos + t_sample'(step);
                s = walk_pos;
            end
            send_sample(s);
        end
    endtask

    // Directed samples: range ends, half-turn boundary, zero on a wrap,
    // count back at zero
    t_sample directed_q[$] = '{
        16'sd0, 16'sd16384, -16'sd1, 16'sd32767, -16'sd32768, 16'sd0,
        16'sd16385, 16'sd0, -16'sd16384, 16'sd1, -16'sd16385, 16'sd0,
        -16'sd32768, 16'sd32767, -16'sd1, 16'sd16383, -16'sd16386,
        16'sd0, 16'sd32767, 16'sd0, -16'sd32767, -16'sd21846, 16'sd21845
    };

    initial begin
        in_if.valid       <= 1'b0;
        in_if.raw_heading <= '0;
        i_rst_n           <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender rarely idles, receiver mostly stalls
        tx_idle_pct = 12;
        rx_idle_pct = 84;
        foreach (directed_q[k])
            send_sample(directed_q[k]);
        send_random(560);

        // Pause the sender until everything is back
        wait_drained();

        // Sender mostly idles, receiver rarely stalls
        tx_idle_pct = 84;
        rx_idle_pct = 12;
        send_random(560);

        // No idling; hold the receiver off long enough to back up the input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold     = 80;
        send_random(60);

        // Run the turn count up through a long string of wraps, then back down
        send_sample(16'sd0);
        repeat (ROLL_STEPS)
            send_sample((last_sent == 16'sd0) ? -16'sd16385 : 16'sd0);
        repeat (ROLL_STEPS)
            send_sample((last_sent == 16'sd16386) ? 16'sd1 : 16'sd16386);

        send_random(440);

        // Drain, then let the pipeline settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
